### hw/rtl/assert_macros.svh
// Assertion macros shared by the fractal pixel unit RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/etfp_pkg.sv
// Shared types and constants for the escape-time fractal pixel unit.
// No dependencies.
package etfp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DIG_W     = 8;
  localparam int N_DIG     = 4;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int TERM_W    = MUL_A_W + DIG_W + 1;
  localparam int WIDE_W    = PROD_W + 1;
  localparam int DCNT_W    = $clog2(N_DIG);

  localparam logic signed [31:0]     ONE_Q     = 32'sh0100_0000;
  localparam logic signed [32:0]     ESC_LIMIT = 33'sh0_0400_0000;
  localparam logic [31:0]            COLOR_STEP = 32'd1000;
  localparam logic [31:0]            COLOR_BASE = 32'd14942208;
  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sh7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(64'sh8000_0000);

  typedef enum logic [2:0] {
    REG_ORIGIN_RE    = 3'd0,
    REG_ORIGIN_IM    = 3'd1,
    REG_STEP_RE      = 3'd2,
    REG_STEP_IM      = 3'd3,
    REG_COLOR_OFFSET = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_GO,
    S_MAP_WAIT,
    S_TEST,
    S_MUL_GO,
    S_MUL_WAIT,
    S_COLOR
  } state_t;

  // Product phase: real part uses xa*za and -xb*zb, imaginary xa*zb and xb*za.
  // Mapping reuses the first two phases for the real and imaginary axis.
  typedef enum logic [1:0] {
    PH_XA_ZA = 2'd0,
    PH_XB_ZB = 2'd1,
    PH_XA_ZB = 2'd2,
    PH_XB_ZA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [9:0]  out_col;
    logic [9:0]  out_row;
    logic [8:0]  iterations;
    logic [31:0] color;
  } pix_out_t;

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        step_re;
    logic [30:0]        step_im;
    logic [31:0]        color_offset;
  } cfg_regs_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/etfp_cfg.sv
// Configuration register file of the fractal pixel unit.
// Depends on etfp_pkg.
module etfp_cfg
  import etfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_regs_t   regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_re    <= '0;
      regs.origin_im    <= '0;
      regs.step_re      <= 31'd65536;
      regs.step_im      <= 31'd65536;
      regs.color_offset <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ORIGIN_RE:    regs.origin_re    <= wr_data;
        REG_ORIGIN_IM:    regs.origin_im    <= wr_data;
        REG_STEP_RE:      regs.step_re      <= wr_data[30:0];
        REG_STEP_IM:      regs.step_im      <= wr_data[30:0];
        REG_COLOR_OFFSET: regs.color_offset <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/etfp_mul.sv
// Digit-serial signed multiplier: 33 x 32 bits, one 8-bit multiplier digit
// per cycle, most significant digit first. Depends on etfp_pkg.
`include "assert_macros.svh"

module etfp_mul
  import etfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic signed [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0]        b_sh;
  logic signed [PROD_W-1:0]  acc;
  logic signed [PROD_W-1:0]  acc_next;
  logic [DCNT_W-1:0]         dcnt;
  logic                      busy;
  logic                      done;
  logic                      first;
  logic                      last;
  logic [DIG_W-1:0]          digit;
  logic signed [DIG_W:0]     dig_s;
  logic signed [TERM_W-1:0]  term;

  assign first = (dcnt == '0);
  assign last  = (dcnt == DCNT_W'(N_DIG - 1));
  assign digit = b_sh[MUL_B_W-1 -: DIG_W];
  assign dig_s = first ? $signed({digit[DIG_W-1], digit}) : $signed({1'b0, digit});

  always_comb begin
    term     = a_r * dig_s;
    acc_next = first ? PROD_W'(term) : (acc <<< DIG_W) + PROD_W'(term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      dcnt <= '0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
        dcnt <= '0;
      end else if (busy) begin
        dcnt <= dcnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_sh <= req.b;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh << DIG_W;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = acc;

  `ASSERT_IMPL(a_mul_done_after_busy, clk, rst, done, $past(busy), "done without a run")
  `ASSERT_IMPL(a_mul_no_restart, clk, rst, req.start, !busy && !done, "start while running")
  `ASSERT_IMPL(a_mul_done_pulse, clk, rst, done, ##1 !done, "done held two cycles")

endmodule

### hw/rtl/escape_time_fractal_pixel_unit.sv
// Escape-time fractal pixel unit: maps (col, row) to a complex point with the
// configured origin and step, iterates z' = x*z, x' = x + z from z = 1 in
// signed saturating Q8.24 until x.re + z.re exceeds 4 or MAX_ITER steps run,
// and returns the count and a color. One item is worked on at a time; every
// product goes through a single shared multiplier that takes one 8-bit digit
// per cycle. Each iteration runs four products and the escape test. A finished
// result waits in an output register while the next item starts.
// Depends on etfp_pkg, etfp_cfg, etfp_mul and assert_macros.svh.
`include "assert_macros.svh"

module escape_time_fractal_pixel_unit
  import etfp_pkg::*;
#(
  parameter int MAX_ITER   = 256,
  parameter int COORD_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pix_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pix_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);

  state_t    state;
  state_t    state_next;
  phase_t    phase;
  cfg_regs_t regs;
  mul_req_t  mreq;
  mul_rsp_t  mrsp;
  pix_in_t   pix;

  logic signed [31:0]        xa;
  logic signed [31:0]        xb;
  logic signed [31:0]        za;
  logic signed [31:0]        zb;
  logic signed [31:0]        na;
  logic signed [PROD_W-1:0]  sum_r;
  logic [CNT_W-1:0]          count;
  logic [9:0]                col_m;
  logic [9:0]                row_m;
  logic signed [32:0]        esc_sum;
  logic                      keep_going;
  logic                      out_free;
  logic                      in_fire;
  logic signed [31:0]        map_re;
  logic signed [31:0]        map_im;
  logic signed [31:0]        mix_val;
  logic [CNT_W-1:0]          diff;
  logic [31:0]               color_raw;
  logic [31:0]               color_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  etfp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  etfp_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      col_m[i] = pix.col[i] & (i < COORD_BITS);
      row_m[i] = pix.row[i] & (i < COORD_BITS);
    end
  end

  assign esc_sum    = 33'(xa) + 33'(za);
  assign keep_going = (esc_sum <= ESC_LIMIT) && (count < CNT_W'(MAX_ITER));

  assign map_re  = sat32(WIDE_W'(mrsp.prod) + WIDE_W'(regs.origin_re));
  assign map_im  = sat32(WIDE_W'(mrsp.prod) + WIDE_W'(regs.origin_im));
  assign mix_val = sat32((WIDE_W'(sum_r) + WIDE_W'(mrsp.prod)) >>> FRAC_BITS);

  assign diff      = CNT_W'(MAX_ITER) - count;
  assign color_raw = 32'(diff) * COLOR_STEP;
  assign color_val = (color_raw == '0) ? '0 : color_raw + COLOR_BASE + regs.color_offset;

  // multiplier operand select
  always_comb begin
    mreq.start = (state == S_MAP_GO) || (state == S_MUL_GO);
    mreq.a     = 33'(xa);
    mreq.b     = za;
    if (state == S_MAP_GO || state == S_MAP_WAIT) begin
      if (phase == PH_XA_ZA) begin
        mreq.a = $signed({2'b00, regs.step_re});
        mreq.b = $signed(32'(col_m));
      end else begin
        mreq.a = $signed({2'b00, regs.step_im});
        mreq.b = $signed(32'(row_m));
      end
    end else begin
      case (phase)
        PH_XA_ZA: begin mreq.a = 33'(xa);    mreq.b = za; end
        PH_XB_ZB: begin mreq.a = -(33'(xb)); mreq.b = zb; end
        PH_XA_ZB: begin mreq.a = 33'(xa);    mreq.b = zb; end
        PH_XB_ZA: begin mreq.a = 33'(xb);    mreq.b = za; end
        default:  begin mreq.a = 33'(xa);    mreq.b = za; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_MAP_GO;
      end
      S_MAP_GO: state_next = S_MAP_WAIT;
      S_MAP_WAIT: begin
        if (mrsp.done) state_next = (phase == PH_XB_ZB) ? S_TEST : S_MAP_GO;
      end
      S_TEST: state_next = keep_going ? S_MUL_GO : S_COLOR;
      S_MUL_GO: state_next = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mrsp.done) state_next = (phase == PH_XB_ZA) ? S_TEST : S_MUL_GO;
      end
      S_COLOR: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_XA_ZA;
      out_valid <= 1'b0;
    end else begin
      if (in_fire || state == S_TEST) begin
        phase <= PH_XA_ZA;
      end else if ((state == S_MAP_WAIT || state == S_MUL_WAIT) && mrsp.done) begin
        phase <= phase_t'(phase + 2'd1);
      end
      if (state == S_COLOR && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix <= in_data;
    end
    if (state == S_MAP_WAIT && mrsp.done) begin
      if (phase == PH_XA_ZA) begin
        xa <= map_re;
      end else begin
        xb    <= map_im;
        za    <= ONE_Q;
        zb    <= '0;
        count <= '0;
      end
    end
    if (state == S_MUL_WAIT && mrsp.done) begin
      case (phase)
        PH_XA_ZA: sum_r <= mrsp.prod;
        PH_XB_ZB: na    <= mix_val;
        PH_XA_ZB: sum_r <= mrsp.prod;
        PH_XB_ZA: begin
          xa    <= sat32(WIDE_W'(xa) + WIDE_W'(za));
          xb    <= sat32(WIDE_W'(xb) + WIDE_W'(zb));
          za    <= na;
          zb    <= mix_val;
          count <= count + 1'b1;
        end
        default: ;
      endcase
    end
    if (state == S_COLOR && out_free) begin
      out_data.out_col    <= pix.col;
      out_data.out_row    <= pix.row;
      out_data.iterations <= 9'(count);
      out_data.color      <= color_val;
    end
  end

  `ASSERT_IMPL(a_iter_below_cap, clk, rst, state == S_MUL_GO, count < CNT_W'(MAX_ITER),
               "iteration started at cap")
  `ASSERT_IMPL(a_done_when_waiting, clk, rst, mrsp.done,
               state == S_MAP_WAIT || state == S_MUL_WAIT, "product finished unexpectedly")
  `ASSERT_IMPL(a_accept_starts_map, clk, rst, in_fire, ##1 state == S_MAP_GO,
               "accepted item did not start mapping")

endmodule
